@@ src/circular_deque_defines.svh @@
// ---------------------------------------------------------------------------
// circular deque assertion macros
// shared property wrappers clocked on i_clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication
`define CDQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cdq_pkg.sv @@
// ---------------------------------------------------------------------------
// cdq_pkg
// shared constants, codes, control structs and index helpers of the deque
// ---------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CAP_W  = 5;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // register index held in paddr above the byte offset
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic load;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, idx} + CNT_W'(1);
        return (inc >= cap) ? '0 : inc[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] last;
        last = cap - CNT_W'(1);
        return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

endpackage

@@ src/cdq_ifs.sv @@
// ---------------------------------------------------------------------------
// cdq channel interfaces
// valid/ready channels for operation requests and results
// ---------------------------------------------------------------------------
interface cdq_in_if;
    logic                             valid;
    logic                             ready;
    logic [cdq_pkg::MODE_W-1:0]       mode;
    logic signed [cdq_pkg::DATA_W-1:0] data_value;

    modport source (output valid, output mode, output data_value, input ready);
    modport sink   (input valid, input mode, input data_value, output ready);
endinterface

interface cdq_out_if;
    logic                             valid;
    logic                             ready;
    logic [cdq_pkg::STAT_W-1:0]       status;
    logic signed [cdq_pkg::DATA_W-1:0] front_value;
    logic signed [cdq_pkg::DATA_W-1:0] rear_value;
    logic                             queue_empty;
    logic                             queue_full;

    modport source (output valid, output status, output front_value, output rear_value,
                    output queue_empty, output queue_full, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input queue_empty, input queue_full, output ready);
endinterface

@@ src/cdq_ram.sv @@
// ---------------------------------------------------------------------------
// cdq_ram
// generic store, one write port and two registered read ports
// ---------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ src/cdq_ctrl.sv @@
// ---------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept, execute, read back, hand over to the output register
// ---------------------------------------------------------------------------
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cdq_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output cdq_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/cdq_dpath.sv @@
// ---------------------------------------------------------------------------
// cdq_dpath
// indices, empty flag, capacity, entry store and result register
// ---------------------------------------------------------------------------
module cdq_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cdq_pkg::t_cmd                    i_cmd,
    input  logic [cdq_pkg::MODE_W-1:0]       i_mode,
    input  logic [cdq_pkg::DATA_W-1:0]       i_data,
    input  logic                             i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]        i_cfg_data,
    input  logic                             i_out_ready,
    output cdq_pkg::t_stat                   o_stat,
    output logic [cdq_pkg::CAP_W-1:0]        o_capacity,
    output logic                             o_out_valid,
    output logic [cdq_pkg::STAT_W-1:0]       o_status,
    output logic [cdq_pkg::DATA_W-1:0]       o_front_value,
    output logic [cdq_pkg::DATA_W-1:0]       o_rear_value,
    output logic                             o_queue_empty,
    output logic                             o_queue_full
);

    logic [cdq_pkg::CAP_W-1:0]  r_cap;
    logic [cdq_pkg::IDX_W-1:0]  r_front;
    logic [cdq_pkg::IDX_W-1:0]  n_front;
    logic [cdq_pkg::IDX_W-1:0]  r_rear;
    logic [cdq_pkg::IDX_W-1:0]  n_rear;
    logic                       r_empty;
    logic                       n_empty;
    logic [cdq_pkg::MODE_W-1:0] r_mode;
    logic [cdq_pkg::DATA_W-1:0] r_data;
    logic [cdq_pkg::STAT_W-1:0] r_status;
    logic [cdq_pkg::STAT_W-1:0] n_status;
    logic                       r_out_valid;
    logic [cdq_pkg::STAT_W-1:0] r_out_status;
    logic [cdq_pkg::DATA_W-1:0] r_out_front;
    logic [cdq_pkg::DATA_W-1:0] r_out_rear;
    logic                       r_out_empty;
    logic                       r_out_full;

    logic [cdq_pkg::CNT_W-1:0]  eff_cap;
    logic                       full;
    logic                       is_push;
    logic                       is_pop;
    logic                       we;
    logic [cdq_pkg::IDX_W-1:0]  waddr;
    logic [cdq_pkg::DATA_W-1:0] rdata_front;
    logic [cdq_pkg::DATA_W-1:0] rdata_rear;

    // zero acts as one, anything beyond the store acts as the store depth
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = cdq_pkg::CNT_W'(1);
        end else if (int'(r_cap) > cdq_pkg::DEPTH) begin
            eff_cap = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
        end else begin
            eff_cap = cdq_pkg::CNT_W'(r_cap);
        end
    end

    assign full    = !r_empty && (cdq_pkg::idx_next(r_rear, eff_cap) == r_front);
    assign is_push = (r_mode == cdq_pkg::MODE_PUSH_FRONT) || (r_mode == cdq_pkg::MODE_PUSH_REAR);
    assign is_pop  = (r_mode == cdq_pkg::MODE_POP_FRONT) || (r_mode == cdq_pkg::MODE_POP_REAR);

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_empty  = r_empty;
        n_status = cdq_pkg::STAT_DONE;
        we       = 1'b0;
        waddr    = '0;
        if (is_push) begin
            if (full) begin
                n_status = cdq_pkg::STAT_FULL;
            end else if (r_empty) begin
                // first entry always lands at index zero
                n_front = '0;
                n_rear  = '0;
                n_empty = 1'b0;
                we      = i_cmd.exec;
            end else if (r_mode == cdq_pkg::MODE_PUSH_FRONT) begin
                n_front = cdq_pkg::idx_prev(r_front, eff_cap);
                waddr   = n_front;
                we      = i_cmd.exec;
            end else begin
                n_rear = cdq_pkg::idx_next(r_rear, eff_cap);
                waddr  = n_rear;
                we     = i_cmd.exec;
            end
        end else if (is_pop) begin
            if (r_empty) begin
                n_status = cdq_pkg::STAT_EMPTY;
            end else if (r_front == r_rear) begin
                n_empty = 1'b1;
                n_front = '0;
                n_rear  = '0;
            end else if (r_mode == cdq_pkg::MODE_POP_FRONT) begin
                n_front = cdq_pkg::idx_next(r_front, eff_cap);
            end else begin
                n_rear = cdq_pkg::idx_prev(r_rear, eff_cap);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= cdq_pkg::CAP_RESET;
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= i_cfg_data;
                r_front <= '0;
                r_rear  <= '0;
                r_empty <= 1'b1;
            end else if (i_cmd.exec) begin
                r_front <= n_front;
                r_rear  <= n_rear;
                r_empty <= n_empty;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_data <= i_data;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_front  <= r_empty ? '0 : rdata_front;
            r_out_rear   <= r_empty ? '0 : rdata_rear;
            r_out_empty  <= r_empty;
            r_out_full   <= full;
        end
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (r_data),
        .i_raddr_a (r_front),
        .i_raddr_b (r_rear),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_capacity      = r_cap;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_front_value   = r_out_front;
    assign o_rear_value    = r_out_rear;
    assign o_queue_empty   = r_out_empty;
    assign o_queue_full    = r_out_full;

endmodule

@@ src/circular_deque.sv @@
// A double-ended queue in a 16-entry circular store whose front and rear indices wrap at
// the programmed capacity (0 behaves as 1, above 16 behaves as 16). Each request
// transaction carries a mode (push front, push rear, pop front, pop rear, query; unused
// codes act as query) and a value; each one yields exactly one result transaction with a
// status (done, rejected full, rejected empty), the front and rear entries after the
// operation (zero while the queue is empty) and the empty and full flags. One request is
// worked at a time: a taken request steps through the execute, read and done states, and
// no new request is taken until its result has been loaded into the output register.
// The states follow the store: the operation writes it, its registered read ports then
// take the new front and rear entries, and the done state loads the output register when
// it is free. A finished result waits in the output register while the next request
// is taken. Writing capacity over the APB port empties the queue; it is meant to happen
// only while the block is idle. No clearing pass is run after reset.
// ---------------------------------------------------------------------------
// circular_deque
// top level: channel and register port wiring, sequencer and datapath
// ---------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module circular_deque (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cdq_in_if.sink                      i_in,
    cdq_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdq_pkg::ADDR_W-1:0]  paddr,
    input  logic [cdq_pkg::PDATA_W-1:0] pwdata,
    output logic [cdq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    cdq_pkg::t_cmd              cmd;
    cdq_pkg::t_stat             stat;
    logic                       cfg_we;
    logic [cdq_pkg::CAP_W-1:0]  capacity;
    logic [cdq_pkg::DATA_W-1:0] front_value;
    logic [cdq_pkg::DATA_W-1:0] rear_value;

    // register port: no wait states, capacity is the only register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr[cdq_pkg::ADDR_W-1] == cdq_pkg::REG_CAPACITY);

    // reads beyond the register list return zero
    assign prdata = (paddr[cdq_pkg::ADDR_W-1] == cdq_pkg::REG_CAPACITY) ?
                    cdq_pkg::PDATA_W'(capacity) : '0;

    // sequencer: takes a request only when nothing is in flight
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // datapath: indices, flags, store and the result register
    cdq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_in.mode),
        .i_data        (i_in.data_value),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (pwdata[cdq_pkg::CAP_W-1:0]),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_capacity    (capacity),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_front_value (front_value),
        .o_rear_value  (rear_value),
        .o_queue_empty (o_out.queue_empty),
        .o_queue_full  (o_out.queue_full)
    );

    assign o_out.front_value = front_value;
    assign o_out.rear_value  = rear_value;

    // full needs at least one entry, so both flags never show together
    `CDQ_ASSERT(a_flags_exclusive, o_out.valid, !(o_out.queue_empty && o_out.queue_full),
                "empty and full together")
    // a rejected push leaves the queue full, a rejected pop leaves it empty
    `CDQ_ASSERT(a_full_reject, o_out.valid && (o_out.status == cdq_pkg::STAT_FULL),
                o_out.queue_full, "full reject without full flag")
    `CDQ_ASSERT(a_empty_reject, o_out.valid && (o_out.status == cdq_pkg::STAT_EMPTY),
                o_out.queue_empty, "empty reject without empty flag")
    // one transaction in flight: no request is taken in the cycle after another
    `CDQ_ASSERT_NEXT(a_one_in_flight, i_in.valid && i_in.ready, !i_in.ready,
                     "request taken while busy")

endmodule

@@ tb/circular_deque_tb.sv @@
// ---------------------------------------------------------------------------
// circular_deque_tb
// drives random and directed deque operations through the request channel,
// predicts every result transaction and compares it field by field, while
// the capacity register is moved over the apb port between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_deque_tb;
    import cdq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 6;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 16;
    // cycles without any transaction before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;
    localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     queue_empty;
        logic                     queue_full;
    } deque_result_t;

    // -----------------------------------------------------------------------
    // scoreboard: own copy of the deque, plus the results still awaited
    // -----------------------------------------------------------------------
    class deque_scoreboard;
        logic signed [DATA_W-1:0] entries [DEPTH];
        int unsigned              head;
        int unsigned              tail;
        bit                       is_empty;
        logic [CAP_W-1:0]         cap_reg;
        deque_result_t            awaited [$];
        int                       mismatches;
        int                       checked;
        int                       full_rejects;
        int                       empty_rejects;
        int                       full_seen;

        function new();
            cap_reg = CAP_RESET;
            head = 0;
            tail = 0;
            is_empty = 1'b1;
        endfunction

        // a capacity write also empties the queue
        function void set_capacity(logic [CAP_W-1:0] value);
            cap_reg = value;
            head = 0;
            tail = 0;
            is_empty = 1'b1;
        endfunction

        function int unsigned active_cap();
            if (cap_reg == '0) return 1;
            if (cap_reg > CAP_W'(DEPTH)) return DEPTH;
            return int'(cap_reg);
        endfunction

        function int unsigned step_on(int unsigned idx, int unsigned cap);
            return (idx + 1 >= cap) ? 0 : idx + 1;
        endfunction

        function int unsigned step_back(int unsigned idx, int unsigned cap);
            return (idx == 0) ? cap - 1 : idx - 1;
        endfunction

        function bit at_capacity(int unsigned cap);
            return !is_empty && step_on(tail, cap) == head;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
            int unsigned   cap;
            deque_result_t exp;
            cap = active_cap();
            exp.status = STAT_DONE;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                    if (at_capacity(cap)) begin
                        exp.status = STAT_FULL;
                        full_rejects++;
                    end else if (is_empty) begin
                        head = 0;
                        tail = 0;
                        is_empty = 1'b0;
                        entries[0] = value;
                    end else if (mode == MODE_PUSH_FRONT) begin
                        head = step_back(head, cap);
                        entries[head] = value;
                    end else begin
                        tail = step_on(tail, cap);
                        entries[tail] = value;
                    end
                end
                MODE_POP_FRONT, MODE_POP_REAR: begin
                    if (is_empty) begin
                        exp.status = STAT_EMPTY;
                        empty_rejects++;
                    end else if (head == tail) begin
                        is_empty = 1'b1;
                        head = 0;
                        tail = 0;
                    end else if (mode == MODE_POP_FRONT) begin
                        head = step_on(head, cap);
                    end else begin
                        tail = step_back(tail, cap);
                    end
                end
                default: ;
            endcase
            exp.queue_empty = is_empty;
            exp.front_value = is_empty ? '0 : entries[head];
            exp.rear_value  = is_empty ? '0 : entries[tail];
            exp.queue_full  = at_capacity(cap);
            if (exp.queue_full) full_seen++;
            awaited.push_back(exp);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 30) $display("[%0t] MISMATCH %s", $realtime, what);
        endtask

        task check_result(deque_result_t got);
            deque_result_t exp;
            if (awaited.size() == 0) begin
                report("result transaction with nothing outstanding");
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got.status !== exp.status)
                report($sformatf("#%0d status got %0d exp %0d", checked, got.status, exp.status));
            if (got.front_value !== exp.front_value)
                report($sformatf("#%0d front got %h exp %h", checked,
                                 got.front_value, exp.front_value));
            if (got.rear_value !== exp.rear_value)
                report($sformatf("#%0d rear got %h exp %h", checked,
                                 got.rear_value, exp.rear_value));
            if (got.queue_empty !== exp.queue_empty)
                report($sformatf("#%0d empty got %b exp %b", checked,
                                 got.queue_empty, exp.queue_empty));
            if (got.queue_full !== exp.queue_full)
                report($sformatf("#%0d full got %b exp %b", checked,
                                 got.queue_full, exp.queue_full));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, reset, channels and the block itself
    // -----------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cdq_in_if  req_ch ();
    cdq_out_if res_ch ();

    circular_deque dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    deque_scoreboard sb = new();

    // idling profile of the current phase, in percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int items_sent     = 0;
    int cap_writes     = 0;

    // result side: ready drops at random according to the stall profile
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: every accepted request updates the prediction, every accepted
    // result is checked against the oldest expectation
    always @(posedge i_clk) begin
        deque_result_t got;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                sb.note_input(req_ch.mode, req_ch.data_value);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.status      = res_ch.status;
                got.front_value = res_ch.front_value;
                got.rear_value  = res_ch.rear_value;
                got.queue_empty = res_ch.queue_empty;
                got.queue_full  = res_ch.queue_full;
                sb.check_result(got);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: a long spell with no transaction at all means a hang
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // one request transaction; valid stays high into the next call unless a
    // gap is drawn, so valid never gets two assignments in one step
    task send_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.data_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // stop sending and wait until every outstanding result has been checked
    task wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // apb write: setup cycle then access cycle, register taken when pready
    task write_capacity(logic [PDATA_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_capacity(value[CAP_W-1:0]);
        cap_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly ordinary values, now and then the signed extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] spare_mode();
        return MODE_W'($urandom_range(int'(MODE_QUERY) + 1, (1 << MODE_W) - 1));
    endfunction

    // random traffic in bursts that lean towards filling or draining, so
    // both the full and the empty boundary are hit again and again
    task run_random(int count, int unsigned cap, bit hold_midway);
        int               left;
        int               burst;
        bit               filling;
        int               roll;
        logic [MODE_W-1:0] mode;
        left = count;
        filling = 1'b1;
        while (left > 0) begin
            burst = $urandom_range(1, 2 * cap + 3);
            for (int k = 0; k < burst && left > 0; k++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    // noise: any code at all, spare ones included
                    mode = MODE_W'($urandom);
                end else if (roll < 12) begin
                    mode = ($urandom_range(1)) ? MODE_QUERY : spare_mode();
                end else if ((roll < 80) == filling) begin
                    mode = ($urandom_range(1)) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
                end else begin
                    mode = ($urandom_range(1)) ? MODE_POP_FRONT : MODE_POP_REAR;
                end
                send_op(mode, pick_value());
                left--;
                // hold the sender back until everything has come out
                if (hold_midway && left == count / 2) wait_drained();
            end
            filling = !filling;
        end
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17,
                                              5'd5, 5'd2};

    initial begin
        int unsigned cap_now;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_QUERY;
        req_ch.data_value <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue rejections, first push, both ends, spare codes
        send_op(MODE_QUERY, '0);
        send_op(MODE_POP_FRONT, '1);
        send_op(MODE_POP_REAR, '1);
        send_op(MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(MODE_PUSH_REAR, 32'sh8000_0000);
        send_op(MODE_PUSH_FRONT, '0);
        send_op(MODE_PUSH_REAR, '1);
        send_op(MODE_QUERY + 3'd1, 32'sh1234_5678);
        send_op(MODE_QUERY + 3'd2, '0);
        send_op(MODE_QUERY + 3'd3, '1);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_REAR, '0);
        send_op(MODE_POP_FRONT, '0);
        // last entry out: both indices go back to zero
        send_op(MODE_POP_REAR, '0);
        send_op(MODE_POP_FRONT, '0);

        // zero capacity behaves as one: a single entry fills the queue
        write_capacity({27'h7FF_FFFF, 5'd0});
        send_op(MODE_PUSH_REAR, 32'sh5555_AAAA);
        send_op(MODE_PUSH_FRONT, 32'shAAAA_5555);
        send_op(MODE_PUSH_REAR, '1);
        send_op(MODE_POP_REAR, '0);

        // capacity two: push at the front wraps the index round
        write_capacity(32'd2);
        send_op(MODE_PUSH_FRONT, 32'sh0F0F_0F0F);
        send_op(MODE_PUSH_FRONT, 32'shF0F0_F0F0);
        send_op(MODE_PUSH_REAR, 32'sh3C3C_3C3C);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_FRONT, '0);

        // random phases, each with its own capacity and idling profile
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            // upper pwdata bits are don't-care, so toggle them at random
            write_capacity({$urandom} & ~PDATA_W'({CAP_W{1'b1}}) | PDATA_W'(phase_caps[p]));
            cap_now = sb.active_cap();
            run_random(PHASE_ITEMS, cap_now, p == 1);
        end

        wait_drained();
        recv_stall_pct = 0;
        repeat (TAIL) @(posedge i_clk);

        $display("covered %0d requests, %0d results over %0d capacity settings",
                 items_sent, sb.checked, cap_writes);
        $display("rejected pushes %0d, rejected pops %0d, full results %0d",
                 sb.full_rejects, sb.empty_rejects, sb.full_seen);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/cdq_pkg.sv
src/cdq_ifs.sv
src/cdq_ram.sv
src/cdq_ctrl.sv
src/cdq_dpath.sv
src/circular_deque.sv
tb/circular_deque_tb.sv
